FILE: hdl/running_mean_pixel_downscaler_defines.svh
`ifndef RUNNING_MEAN_PIXEL_DOWNSCALER_DEFINES_SVH
`define RUNNING_MEAN_PIXEL_DOWNSCALER_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define RMPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RMPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rmpd_pkg.sv
package rmpd_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_VALID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALED_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q16     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_SHIFT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_SHIFT   = 3'd7;

  localparam logic [16:0] SCALE_ONE = 17'h10000;
  localparam logic [7:0]  BYTE_MAX  = 8'hFF;

  localparam int LIN_W = 25;         // dest_x + dest_y * dest_width fits 25 bits
  localparam int MUL_A_W = 12;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MX,
    S_MY,
    S_DY,
    S_MA,
    S_LIN,
    S_MOD,
    S_RD,
    S_MC,
    S_DS,
    S_DW,
    S_WR
  } rmpd_state_t;

  typedef struct packed {
    logic frame_we;
    logic count_we;
  } rmpd_wr_t;

endpackage

FILE: hdl/running_mean_pixel_downscaler.sv
// Scaled mode, from accepted beat to result beat: 5 address steps, one store read,
//   then per channel a multiply and an 8-step shared divider, then the write.
// Direct mode: address steps S_MA and S_LIN, then the write. A non power-of-two store
//   depth adds a modulo pass (S_MOD). The sequencer takes one pixel at a time.
// Reset: synchronous, active low; then a hit-count clearing pass over all
//   MAX_DEST_PIXELS entries with in_tready low (config writes still taken).
`include "running_mean_pixel_downscaler_defines.svh"

module running_mean_pixel_downscaler
  import rmpd_pkg::*;
#(
  parameter int MAX_DEST_PIXELS = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel_x[11:0], pixel_y[23:12], red_in[31:24], green_in[39:32], blue_in[47:40],
  // blue_shift_in[52:48], zero fill
  input  logic [55:0]           in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // dest_x[11:0], dest_y[23:12], red_out[31:24], green_out[39:32], blue_out[47:40],
  // packed_word[79:48]
  output logic [79:0]           out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(MAX_DEST_PIXELS);
  localparam bit ADDR_POW2 = (MAX_DEST_PIXELS & (MAX_DEST_PIXELS - 1)) == 0;
  localparam int MOD_W = LIN_W + 1;
  localparam int MOD_STEPS = LIN_W + 1 - ADDR_W;
  localparam logic [MOD_W-1:0] MOD_TOP = MOD_W'(MAX_DEST_PIXELS) << (MOD_STEPS - 1);

  // configuration
  logic        display_valid_r, scaled_enable_r;
  logic [16:0] scale_q16_r;
  logic [12:0] src_width_r, src_height_r, dest_width_r;
  logic [4:0]  red_shift_r, green_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_valid_r <= 1'b0;
      scaled_enable_r <= 1'b0;
      scale_q16_r     <= SCALE_ONE;
      src_width_r     <= 13'd4096;
      src_height_r    <= 13'd4096;
      dest_width_r    <= 13'd256;
      red_shift_r     <= 5'd16;
      green_shift_r   <= 5'd8;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DISPLAY_VALID: display_valid_r <= cfg_data[0];
        CFG_SCALED_ENABLE: scaled_enable_r <= cfg_data[0];
        CFG_SCALE_Q16:     scale_q16_r     <= cfg_data;
        CFG_SRC_WIDTH:     src_width_r     <= cfg_data[12:0];
        CFG_SRC_HEIGHT:    src_height_r    <= cfg_data[12:0];
        CFG_DEST_WIDTH:    dest_width_r    <= cfg_data[12:0];
        CFG_RED_SHIFT:     red_shift_r     <= cfg_data[4:0];
        CFG_GREEN_SHIFT:   green_shift_r   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // input fields
  logic [11:0] in_x, in_y;
  logic [7:0]  in_r, in_g, in_b;
  logic [4:0]  in_bs;
  logic        in_fire, pix_ok;

  assign in_x  = in_tdata[11:0];
  assign in_y  = in_tdata[23:12];
  assign in_r  = in_tdata[31:24];
  assign in_g  = in_tdata[39:32];
  assign in_b  = in_tdata[47:40];
  assign in_bs = in_tdata[52:48];

  assign in_fire = in_tvalid && in_tready;
  assign pix_ok  = display_valid_r && ({1'b0, in_x} < src_width_r) &&
                   ({1'b0, in_y} < src_height_r);

  // sequencer state
  rmpd_state_t state_r, state_nxt;
  logic [11:0] x_r, x_nxt, y_r, y_nxt, dx_r, dx_nxt, dy_r, dy_nxt;
  logic [7:0]  r_r, r_nxt, g_r, g_nxt, b_r, b_nxt;
  logic [4:0]  bs_r, bs_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [MOD_W-1:0] mod_r, mod_nxt, msub_r, msub_nxt;
  logic [4:0]  mstep_r, mstep_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [79:0] out_tdata_r, out_tdata_nxt;

  // shared units
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic        div_start, div_done;
  logic [15:0] div_num;
  logic [8:0]  div_den;
  logic [7:0]  div_quo;
  rmpd_wr_t    wr;
  logic        rd_en, clr_busy;
  logic [31:0] rd_word, wr_word;
  logic [7:0]  rd_count, wr_count;

  rmpd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  rmpd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  rmpd_store #(
    .DEPTH (MAX_DEST_PIXELS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .addr     (mod_r[ADDR_W-1:0]),
    .rd_en    (rd_en),
    .wr       (wr),
    .wr_word  (wr_word),
    .wr_count (wr_count),
    .rd_word  (rd_word),
    .rd_count (rd_count),
    .clr_busy (clr_busy)
  );

  logic [16:0] sc;
  logic [4:0]  sh_sel;
  logic [7:0]  old_byte, new_byte;
  logic        mod_ge;

  assign sc = (scale_q16_r > SCALE_ONE) ? SCALE_ONE : scale_q16_r;

  always_comb begin
    case (ch_r)
      2'd0:    begin sh_sel = red_shift_r;   new_byte = r_r; end
      2'd1:    begin sh_sel = green_shift_r; new_byte = g_r; end
      default: begin sh_sel = bs_r;          new_byte = b_r; end
    endcase
  end

  assign old_byte = 8'(rd_word >> sh_sel);
  assign mod_ge   = mod_r >= msub_r;
  assign wr_word  = (32'(r_r) << red_shift_r) | (32'(g_r) << green_shift_r) |
                    (32'(b_r) << bs_r);
  assign wr_count = rd_count + 8'd1;
  assign div_num  = mul_p[15:0] + 16'(new_byte);
  assign div_den  = {1'b0, rd_count} + 9'd1;

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;
    y_nxt = y_r;
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    r_nxt = r_r;
    g_nxt = g_r;
    b_nxt = b_r;
    bs_nxt = bs_r;
    ch_nxt = ch_r;
    mod_nxt = mod_r;
    msub_nxt = msub_r;
    mstep_nxt = mstep_r;
    out_tdata_nxt = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    rd_en = 1'b0;
    wr = '0;
    in_tready = (state_r == S_IDLE) && !clr_busy;

    case (state_r)
      S_IDLE: begin
        if (in_fire && pix_ok) begin
          x_nxt = in_x;
          y_nxt = in_y;
          dx_nxt = in_x;
          dy_nxt = in_y;
          r_nxt = in_r;
          g_nxt = in_g;
          b_nxt = in_b;
          bs_nxt = in_bs;
          state_nxt = scaled_enable_r ? S_MX : S_MA;
        end
      end
      S_MX: begin
        mul_a = x_r;
        mul_b = sc;
        state_nxt = S_MY;
      end
      S_MY: begin
        dx_nxt = mul_p[27:16];
        mul_a = y_r;
        mul_b = sc;
        state_nxt = S_DY;
      end
      S_DY: begin
        dy_nxt = mul_p[27:16];
        state_nxt = S_MA;
      end
      S_MA: begin
        mul_a = dy_r;
        mul_b = 17'(dest_width_r);
        state_nxt = S_LIN;
      end
      S_LIN: begin
        mod_nxt = MOD_W'(dx_r) + MOD_W'(mul_p[LIN_W-1:0]);
        msub_nxt = MOD_TOP;
        mstep_nxt = 5'(MOD_STEPS - 1);
        if (!ADDR_POW2) begin
          state_nxt = S_MOD;
        end else begin
          state_nxt = scaled_enable_r ? S_RD : S_WR;
        end
      end
      S_MOD: begin
        if (mod_ge) begin
          mod_nxt = mod_r - msub_r;
        end
        msub_nxt = msub_r >> 1;
        if (mstep_r == 5'd0) begin
          state_nxt = scaled_enable_r ? S_RD : S_WR;
        end else begin
          mstep_nxt = mstep_r - 5'd1;
        end
      end
      S_RD: begin
        rd_en = 1'b1;
        ch_nxt = 2'd0;
        state_nxt = S_MC;
      end
      S_MC: begin
        mul_a = 12'(old_byte);
        mul_b = 17'(rd_count);
        state_nxt = S_DS;
      end
      S_DS: begin
        div_start = 1'b1;
        state_nxt = S_DW;
      end
      S_DW: begin
        if (div_done) begin
          case (ch_r)
            2'd0:    r_nxt = div_quo;
            2'd1:    g_nxt = div_quo;
            default: b_nxt = div_quo;
          endcase
          if (ch_r == 2'd2) begin
            state_nxt = S_WR;
          end else begin
            ch_nxt = ch_r + 2'd1;
            state_nxt = S_MC;
          end
        end
      end
      S_WR: begin
        if (!out_tvalid_r || out_tready) begin
          wr.frame_we = 1'b1;
          wr.count_we = scaled_enable_r && (rd_count != BYTE_MAX);
          out_tdata_nxt = {wr_word, b_r, g_r, r_r, dy_r, dx_r};
          out_tvalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_tvalid_r <= 1'b0;
      ch_r <= '0;
      mstep_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      ch_r <= ch_nxt;
      mstep_r <= mstep_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    r_r <= r_nxt;
    g_r <= g_nxt;
    b_r <= b_nxt;
    bs_r <= bs_nxt;
    mod_r <= mod_nxt;
    msub_r <= msub_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  `RMPD_ASSERT_NOW(a_div_done_in_wait, div_done, state_r == S_DW, "divider done outside wait")
  `RMPD_ASSERT_NOW(a_no_write_clearing, wr.frame_we || wr.count_we, !clr_busy, "store write during clear")
  `RMPD_ASSERT_NOW(a_ch_range, state_r == S_DW || state_r == S_MC, ch_r != 2'd3, "bad channel")
  `RMPD_ASSERT_NEXT(a_result_loaded, state_r == S_WR && state_nxt == S_IDLE, out_tvalid_r, "result lost")

endmodule

FILE: hdl/rmpd_mul.sv
module rmpd_mul
  import rmpd_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  logic [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign p = p_r;

endmodule

FILE: hdl/rmpd_div.sv
module rmpd_div
  import rmpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [8:0]  den,
  output logic        done,
  output logic [7:0]  quo
);

  // restoring radix-2, quotient known to fit 8 bits (num < 256 * den)
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] dsh_r, dsh_nxt;
  logic [7:0]  q_r, q_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        ge;

  assign ge = {1'b0, rem_r} >= dsh_r;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = {1'b0, den, 7'd0};
      q_nxt    = '0;
      step_nxt = 3'd7;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r[15:0];
      end
      q_nxt   = {q_r[6:0], ge};
      dsh_nxt = dsh_r >> 1;
      if (step_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

FILE: hdl/rmpd_store.sv
module rmpd_store
  import rmpd_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] addr,
  input  logic              rd_en,
  input  rmpd_wr_t          wr,
  input  logic [31:0]       wr_word,
  input  logic [7:0]        wr_count,
  output logic [31:0]       rd_word,
  output logic [7:0]        rd_count,
  output logic              clr_busy
);

  logic [31:0] frame_mem [DEPTH];
  logic [7:0]  count_mem [DEPTH];

  logic [31:0] rd_word_r;
  logic [7:0]  rd_count_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic        clr_busy_r;

  // count clearing pass after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.frame_we) begin
      frame_mem[addr] <= wr_word;
    end
    if (rd_en) begin
      rd_word_r <= frame_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      count_mem[clr_addr_r] <= '0;
    end else if (wr.count_we) begin
      count_mem[addr] <= wr_count;
    end
    if (rd_en) begin
      rd_count_r <= count_mem[addr];
    end
  end

  assign rd_word  = rd_word_r;
  assign rd_count = rd_count_r;
  assign clr_busy = clr_busy_r;

endmodule

FILE: test/running_mean_pixel_downscaler_checker.sv
`timescale 1ns / 1ps

module running_mean_pixel_downscaler_checker
  import rmpd_pkg::*;
#(
  parameter int STORE_DEPTH = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel_x[11:0], pixel_y[23:12], red_in[31:24], green_in[39:32], blue_in[47:40],
  // blue_shift_in[52:48], zero fill
  input  logic [55:0]           in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // dest_x[11:0], dest_y[23:12], red_out[31:24], green_out[39:32], blue_out[47:40],
  // packed_word[79:48]
  input  logic [79:0]           out_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    writes_owed,
  output int                    mismatches
);

  // same layout as out_tdata
  typedef struct packed {
    logic [31:0] word;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] dy;
    logic [11:0] dx;
  } store_write_t;

  logic [31:0]  frame_words [STORE_DEPTH];
  logic [7:0]   hit_counts  [STORE_DEPTH];
  logic         disp_on;
  logic         scaled_on;
  logic [16:0]  scale;
  logic [12:0]  src_w;
  logic [12:0]  src_h;
  logic [12:0]  dst_w;
  logic [4:0]   red_sh;
  logic [4:0]   green_sh;
  store_write_t owed_writes [$];
  int           err_cnt = 0;

  function automatic logic [7:0] byte_at(input logic [31:0] w, input logic [4:0] sh);
    return 8'(w >> sh);
  endfunction

  function automatic logic [7:0] running_mean(input logic [7:0] prev, hits, fresh);
    int unsigned num;
    num = int'(prev) * int'(hits) + int'(fresh);
    return 8'(num / (int'(hits) + 1));
  endfunction

  function automatic logic [31:0] pack_word(input logic [7:0] r, g, b,
                                            input logic [4:0] rs, gs, bs);
    logic [63:0] w;
    w = (64'(r) << rs) | (64'(g) << gs) | (64'(b) << bs);
    return w[31:0];
  endfunction

  // folds one pixel into the shadow store; returns 0 when the pixel is dropped
  function automatic bit predict_store_write(input logic [55:0] beat,
                                             output store_write_t wr);
    logic [11:0] x, y;
    logic [7:0]  r, g, b, hits;
    logic [4:0]  bs;
    logic [16:0] sc;
    logic [28:0] px, py;
    logic [31:0] prev;
    int          addr;
    x  = beat[11:0];
    y  = beat[23:12];
    r  = beat[31:24];
    g  = beat[39:32];
    b  = beat[47:40];
    bs = beat[52:48];
    wr = '0;
    if (!disp_on || 13'(x) >= src_w || 13'(y) >= src_h) return 1'b0;
    if (scaled_on) begin
      sc = (scale > SCALE_ONE) ? SCALE_ONE : scale;
      px = 29'(x) * 29'(sc);
      py = 29'(y) * 29'(sc);
      wr.dx = px[27:16];
      wr.dy = py[27:16];
    end else begin
      wr.dx = x;
      wr.dy = y;
    end
    addr = (int'(wr.dx) + int'(wr.dy) * int'(dst_w)) % STORE_DEPTH;
    if (scaled_on) begin
      prev = frame_words[addr];
      hits = hit_counts[addr];
      r = running_mean(byte_at(prev, red_sh), hits, r);
      g = running_mean(byte_at(prev, green_sh), hits, g);
      b = running_mean(byte_at(prev, bs), hits, b);
      if (hits != BYTE_MAX) hit_counts[addr] = hits + 8'd1;
    end
    wr.red   = r;
    wr.green = g;
    wr.blue  = b;
    wr.word  = pack_word(r, g, b, red_sh, green_sh, bs);
    frame_words[addr] = wr.word;
    return 1'b1;
  endfunction

  function automatic void note_field(input string field, input logic [31:0] want, got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    store_write_t wr;
    store_write_t got;
    if (!rst_n) begin
      owed_writes.delete();
      foreach (hit_counts[i]) hit_counts[i] = '0;
      disp_on   = 1'b0;
      scaled_on = 1'b0;
      scale     = SCALE_ONE;
      src_w     = 13'd4096;
      src_h     = 13'd4096;
      dst_w     = 13'd256;
      red_sh    = 5'd16;
      green_sh  = 5'd8;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DISPLAY_VALID: disp_on   = cfg_data[0];
          CFG_SCALED_ENABLE: scaled_on = cfg_data[0];
          CFG_SCALE_Q16:     scale     = cfg_data;
          CFG_SRC_WIDTH:     src_w     = cfg_data[12:0];
          CFG_SRC_HEIGHT:    src_h     = cfg_data[12:0];
          CFG_DEST_WIDTH:    dst_w     = cfg_data[12:0];
          CFG_RED_SHIFT:     red_sh    = cfg_data[4:0];
          CFG_GREEN_SHIFT:   green_sh  = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (predict_store_write(in_tdata, wr)) owed_writes.push_back(wr);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (owed_writes.size() == 0) begin
          $display("%0t ns: result beat %0h with none expected", $time, got);
          err_cnt++;
        end else begin
          wr = owed_writes.pop_front();
          note_field("dest_x", 32'(wr.dx), 32'(got.dx));
          note_field("dest_y", 32'(wr.dy), 32'(got.dy));
          note_field("red_out", 32'(wr.red), 32'(got.red));
          note_field("green_out", 32'(wr.green), 32'(got.green));
          note_field("blue_out", 32'(wr.blue), 32'(got.blue));
          note_field("packed_word", wr.word, got.word);
        end
      end
    end
    writes_owed <= owed_writes.size();
    mismatches  <= err_cnt;
  end

endmodule

FILE: test/running_mean_pixel_downscaler_tb.sv
`timescale 1ns / 1ps

module running_mean_pixel_downscaler_tb;
  import rmpd_pkg::*;

  localparam int STORE_DEPTH   = 65536;
  localparam int SETTLE_CYCLES = 60;
  localparam int PIXEL_TARGET  = 700;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic [55:0]           in_tdata  = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [79:0]           out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  int                    writes_owed;
  int                    mismatches;

  // settings as last written, used to steer coordinates onto written entries
  logic        sh_disp   = 1'b0;
  logic        sh_scaled = 1'b0;
  logic [16:0] sh_scale  = SCALE_ONE;
  logic [12:0] sh_src_w  = 13'd4096;
  logic [12:0] sh_src_h  = 13'd4096;
  logic [12:0] sh_dst_w  = 13'd256;
  bit          written [STORE_DEPTH];
  logic [23:0] recent_xy [$];
  int          burst_left    = 0;
  int          pixels_sent   = 0;
  int          stall_left    = 0;
  int          stall_pct     = 0;
  int          ready_cycle   = 0;

  running_mean_pixel_downscaler #(.MAX_DEST_PIXELS(STORE_DEPTH)) dut (.*);

  running_mean_pixel_downscaler_checker #(.STORE_DEPTH(STORE_DEPTH)) write_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(8_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // receiver back-pressure, switching between none, light and heavy
  always @(posedge clk) begin
    ready_cycle++;
    if (ready_cycle % 400 == 0) begin
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        default: stall_pct = 60;
      endcase
    end
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 16);
    end
  end

  function automatic bit lands_at(input logic [11:0] x, y, output int addr);
    logic [16:0] sc;
    logic [28:0] px, py;
    logic [11:0] dx, dy;
    sc = (sh_scale > SCALE_ONE) ? SCALE_ONE : sh_scale;
    px = 29'(x) * 29'(sc);
    py = 29'(y) * 29'(sc);
    dx = sh_scaled ? px[27:16] : x;
    dy = sh_scaled ? py[27:16] : y;
    addr = (int'(dx) + int'(dy) * int'(sh_dst_w)) % STORE_DEPTH;
    return sh_disp && 13'(x) < sh_src_w && 13'(y) < sh_src_h;
  endfunction

  function automatic int span(input logic [12:0] w);
    return (w == 0 || w > 13'd4096) ? 4096 : int'(w);
  endfunction

  function automatic logic [12:0] pick_size();
    case ($urandom_range(0, 3))
      0:       return 13'd4096;
      1:       return 13'd1;
      2:       return 13'd64;
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  task automatic apply_settings(input logic dv, se, input logic [16:0] sc,
                                input logic [12:0] sw, sh, dw, input logic [4:0] rs, gs);
    logic [CFG_IDX_W-1:0]  regs [8];
    logic [CFG_DATA_W-1:0] vals [8];
    regs = '{CFG_DISPLAY_VALID, CFG_SCALED_ENABLE, CFG_SCALE_Q16, CFG_SRC_WIDTH,
             CFG_SRC_HEIGHT, CFG_DEST_WIDTH, CFG_RED_SHIFT, CFG_GREEN_SHIFT};
    vals = '{17'(dv), 17'(se), sc, 17'(sw), 17'(sh), 17'(dw), 17'(rs), 17'(gs)};
    for (int i = 0; i < 8; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    sh_disp   = dv;
    sh_scaled = se;
    sh_scale  = sc;
    sh_src_w  = sw;
    sh_src_h  = sh;
    sh_dst_w  = dw;
  endtask

  task automatic send_pixel(input logic [11:0] x, y, input logic [7:0] r, g, b,
                            input logic [4:0] bs);
    int addr;
    bit hit;
    hit = lands_at(x, y, addr);
    // a scaled pixel must land on an entry some earlier pixel wrote; (0,0) always has
    if (hit && sh_scaled && !written[addr]) begin
      x = '0;
      y = '0;
      hit = lands_at(x, y, addr);
    end
    in_tdata  <= {3'b000, bs, b, g, r, y, x};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
    if (hit) begin
      written[addr] = 1'b1;
      recent_xy.push_back({y, x});
      if (recent_xy.size() > 64) void'(recent_xy.pop_front());
    end
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (writes_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase();
    logic        dv, se;
    logic [16:0] sc;
    logic [12:0] sw, sh, dw;
    logic [11:0] x, y;
    logic [23:0] xy;
    int          addr;
    dv = ($urandom_range(0, 9) != 0);
    se = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0:       sc = SCALE_ONE;
      1:       sc = 17'd1;
      2:       sc = 17'h08000;
      3:       sc = 17'h02000;
      default: sc = 17'($urandom_range(1, 65536));
    endcase
    sw = pick_size();
    sh = pick_size();
    dw = $urandom_range(0, 1) ? sh_dst_w : pick_size();
    apply_settings(dv, se, sc, sw, sh, dw, 5'($urandom_range(0, 24)),
                   5'($urandom_range(0, 24)));
    repeat ($urandom_range(20, 60)) begin
      for (int t = 0; t < 32; t++) begin
        if (recent_xy.size() != 0 && $urandom_range(0, 1)) begin
          xy = recent_xy[$urandom_range(0, recent_xy.size() - 1)];
          {y, x} = xy;
        end else if ($urandom_range(0, 9) == 0) begin
          x = 12'($urandom_range(0, 4095));
          y = 12'($urandom_range(0, 4095));
        end else begin
          x = 12'($urandom_range(0, span(sh_src_w) - 1));
          y = 12'($urandom_range(0, span(sh_src_h) - 1));
        end
        if (!sh_scaled || !lands_at(x, y, addr) || written[addr]) break;
      end
      send_pixel(x, y, 8'($urandom), 8'($urandom), 8'($urandom),
                 5'($urandom_range(0, 24)));
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // direct writes seed an 8x8 block so scaled reads have data
    apply_settings(1'b1, 1'b0, SCALE_ONE, 13'd4096, 13'd4096, 13'd8, 5'd16, 5'd8);
    for (int row = 0; row < 8; row++)
      for (int col = 0; col < 8; col++)
        send_pixel(12'(col), 12'(row), 8'($urandom), 8'($urandom), 8'($urandom),
                   5'($urandom_range(0, 24)));
    drain();

    apply_settings(1'b1, 1'b0, SCALE_ONE, 13'd4096, 13'd4096, 13'd4096, 5'd24, 5'd0);
    send_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 5'd24);
    send_pixel(12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 5'd0);
    send_pixel(12'hFFF, 12'h000, 8'hFF, 8'h00, 8'hFF, 5'd16);
    send_pixel(12'h000, 12'hFFF, 8'h00, 8'hFF, 8'h00, 5'd8);
    drain();

    // first column and row past the source are dropped
    apply_settings(1'b1, 1'b0, SCALE_ONE, 13'd100, 13'd50, 13'd8, 5'd16, 5'd8);
    send_pixel(12'd100, 12'd0, 8'h12, 8'h34, 8'h56, 5'd0);
    send_pixel(12'd0, 12'd50, 8'h12, 8'h34, 8'h56, 5'd0);
    send_pixel(12'd99, 12'd49, 8'h81, 8'h42, 8'h24, 5'd0);
    send_pixel(12'hFFF, 12'hFFF, 8'h81, 8'h42, 8'h24, 5'd0);
    drain();

    apply_settings(1'b0, 1'b0, SCALE_ONE, 13'd4096, 13'd4096, 13'd8, 5'd16, 5'd8);
    send_pixel(12'd3, 12'd3, 8'h11, 8'h22, 8'h33, 5'd0);
    drain();

    apply_settings(1'b1, 1'b0, SCALE_ONE, 13'd0, 13'd0, 13'd8, 5'd16, 5'd8);
    send_pixel(12'd0, 12'd0, 8'h11, 8'h22, 8'h33, 5'd0);
    drain();

    // shifts past the top byte: upper bits fall off, channels overlap
    apply_settings(1'b1, 1'b0, SCALE_ONE, 13'd4096, 13'd4096, 13'd8, 5'd31, 5'd28);
    send_pixel(12'd5, 12'd0, 8'hAA, 8'h55, 8'hF0, 5'd24);
    drain();

    apply_settings(1'b1, 1'b1, SCALE_ONE, 13'd4096, 13'd4096, 13'd4096, 5'd24, 5'd0);
    send_pixel(12'hFFF, 12'hFFF, 8'h00, 8'h00, 8'h00, 5'd24);
    send_pixel(12'h000, 12'h000, 8'hFF, 8'hFF, 8'hFF, 5'd0);
    drain();

    // scale above one behaves as one
    apply_settings(1'b1, 1'b1, 17'h1FFFF, 13'd4096, 13'd4096, 13'd4096, 5'd16, 5'd8);
    send_pixel(12'hFFF, 12'h000, 8'h7F, 8'h80, 8'h01, 5'd0);
    send_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 5'd24);
    drain();

    apply_settings(1'b1, 1'b1, 17'h02000, 13'd64, 13'd64, 13'd8, 5'd16, 5'd8);
    send_pixel(12'd63, 12'd63, 8'hFF, 8'h00, 8'h80, 5'd0);
    send_pixel(12'd8, 12'd8, 8'h10, 8'h20, 8'h30, 5'd0);
    send_pixel(12'd0, 12'd0, 8'hFE, 8'h01, 8'h7F, 5'd0);
    drain();

    // zero scale folds every pixel into one entry, also after its count saturates
    apply_settings(1'b1, 1'b1, 17'd0, 13'd4096, 13'd4096, 13'd8, 5'd16, 5'd8);
    repeat (270)
      send_pixel(12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 5'($urandom_range(0, 24)));
    drain();

    while (pixels_sent < PIXEL_TARGET) random_phase();

    if (mismatches == 0 && writes_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
